>>> rtl/process_slot_pool_ready_queue_unit_assert.svh
// Assertion shorthands for the ready queue unit.
// Every check samples on the rising edge of clk and is off while rst_n is low.
`ifndef PROCESS_SLOT_POOL_READY_QUEUE_UNIT_ASSERT_SVH
`define PROCESS_SLOT_POOL_READY_QUEUE_UNIT_ASSERT_SVH

// Check that a property holds at every sampled edge.
`define PSPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cons holds at every edge where ante holds.
`define PSPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/pspq_pkg.sv
package pspq_pkg;

  // Link storage covers the slots that the 3-bit slot field can name.
  localparam int LINK_DEPTH = 8;

  typedef logic [2:0] slot_t;
  typedef logic [3:0] count_t;

  typedef enum logic [1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_ENQUEUE = 2'd2,
    MODE_DEQUEUE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_REFUSED = 2'd2
  } status_t;

  // Result of the free slot search.
  typedef struct packed {
    logic  found;
    slot_t slot;
  } pick_t;

endpackage

>>> rtl/pspq_free_find.sv
module pspq_free_find #(
  parameter int SLOT_COUNT = 8
) (
  input  logic [SLOT_COUNT-1:0] in_use,
  output logic [SLOT_COUNT-1:0] grant,
  output pspq_pkg::pick_t       pick
);
  import pspq_pkg::*;

  // Lowest free slot wins.
  always_comb begin
    logic seen;
    seen  = 1'b0;
    grant = '0;
    pick  = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!in_use[i] && !seen) begin
        grant[i]   = 1'b1;
        pick.found = 1'b1;
        pick.slot  = 3'(i);
        seen       = 1'b1;
      end
    end
  end

endmodule

>>> rtl/process_slot_pool_ready_queue_unit.sv
// Channel  Ports      Dir  tdata fields (low bit first)
// in       in_t*      in   mode[1:0], slot[4:2], zero pad[7:5]
// out      out_t*     out  result_slot[2:0], status[4:3], zero pad[7:5]
//
// One request per cycle sustained while out_tready holds; each transfer passes
// through the input register and leaves from the result register.
// The pool and queue update in a single pass over the link registers.
// rst_n (synchronous) frees every slot and empties the queue; link registers
// are not reset and are written before they are ever read.
// A stalled result holds the result register and, behind it, the input register.
module process_slot_pool_ready_queue_unit #(
  parameter int SLOT_COUNT = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // mode[1:0], slot[4:2], pad[7:5]
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // result_slot[2:0], status[4:3], pad[7:5]
);
  import pspq_pkg::*;

  // Input register stage.
  logic  s1_valid_r, s1_valid_nxt;
  mode_t s1_mode_r;
  slot_t s1_slot_r;
  logic  s1_adv, s1_fire, in_fire;

  // Pool and queue state.
  logic [SLOT_COUNT-1:0] in_use_r, in_use_nxt;
  logic [LINK_DEPTH-1:0] queued_r, queued_nxt;
  slot_t                 next_r [LINK_DEPTH];
  slot_t                 next_nxt [LINK_DEPTH];
  slot_t                 prev_r [LINK_DEPTH];
  slot_t                 prev_nxt [LINK_DEPTH];
  slot_t                 head_r, head_nxt;
  slot_t                 tail_r, tail_nxt;
  count_t                count_r, count_nxt;

  // Result register.
  logic    out_valid_r, out_valid_nxt;
  slot_t   out_slot_r, res_slot;
  status_t out_status_r, res_status;

  // Working signals.
  logic [LINK_DEPTH-1:0] in_use_low;
  logic [SLOT_COUNT-1:0] rel_mask, grant;
  pick_t                 pick;
  slot_t                 rd_addr, nx, pv, tail_fit;
  logic                  do_unlink;

  // --- handshake ---------------------------------------------------------
  // Advance the input stage whenever the result register is free or drains.
  assign s1_adv     = !out_valid_r || out_tready;
  assign s1_fire    = s1_valid_r && s1_adv;
  assign in_tready  = !s1_valid_r || s1_adv;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_status_r, out_slot_r};

  assign s1_valid_nxt  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_fire ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  // --- slot views --------------------------------------------------------
  // Low eight slots as seen by release and enqueue; slots beyond the pool
  // read as free, so a request for them is refused.
  for (genvar g = 0; g < LINK_DEPTH; g++) begin : g_low
    if (g < SLOT_COUNT) begin : g_in
      assign in_use_low[g] = in_use_r[g];
    end else begin : g_out
      assign in_use_low[g] = 1'b0;
    end
  end

  // Slot addressed by a release, as a mask over the whole pool.
  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_rel
    if (g < LINK_DEPTH) begin : g_hit
      assign rel_mask[g] = (s1_slot_r == 3'(g));
    end else begin : g_miss
      assign rel_mask[g] = 1'b0;
    end
  end

  pspq_free_find #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_free_find (
    .in_use(in_use_r),
    .grant (grant),
    .pick  (pick)
  );

  // One link read per array: the head for dequeue, the request slot otherwise.
  assign rd_addr  = (s1_mode_r == MODE_DEQUEUE) ? head_r : s1_slot_r;
  assign nx       = (int'(next_r[rd_addr]) < SLOT_COUNT) ? next_r[rd_addr] : '0;
  assign pv       = (int'(prev_r[rd_addr]) < SLOT_COUNT) ? prev_r[rd_addr] : '0;
  assign tail_fit = (int'(tail_r) < SLOT_COUNT) ? tail_r : '0;

  // Unlink a queued slot on release, or the head on dequeue.
  assign do_unlink = s1_fire &&
                     (((s1_mode_r == MODE_RELEASE) && in_use_low[s1_slot_r] &&
                       queued_r[s1_slot_r]) ||
                      ((s1_mode_r == MODE_DEQUEUE) && (count_r != '0)));

  // --- single-pass update ------------------------------------------------
  always_comb begin
    in_use_nxt = in_use_r;
    queued_nxt = queued_r;
    next_nxt   = next_r;
    prev_nxt   = prev_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    res_slot   = '0;
    res_status = ST_OK;

    if (s1_fire) begin
      unique case (s1_mode_r)
        MODE_ALLOC: begin
          if (pick.found) begin
            in_use_nxt = in_use_r | grant;
            res_slot   = pick.slot;
          end else begin
            res_status = ST_EMPTY;
          end
        end
        MODE_RELEASE: begin
          if (!in_use_low[s1_slot_r]) begin
            res_status = ST_REFUSED;
          end else begin
            in_use_nxt = in_use_r & ~rel_mask;
          end
        end
        MODE_ENQUEUE: begin
          if (!in_use_low[s1_slot_r] || queued_r[s1_slot_r]) begin
            res_status = ST_REFUSED;
          end else begin
            if (count_r == '0) begin
              head_nxt            = s1_slot_r;
              prev_nxt[s1_slot_r] = '0;
            end else begin
              next_nxt[tail_fit]  = s1_slot_r;
              prev_nxt[s1_slot_r] = tail_fit;
            end
            // Terminate the new tail.
            next_nxt[s1_slot_r]   = '0;
            tail_nxt              = s1_slot_r;
            queued_nxt[s1_slot_r] = 1'b1;
            count_nxt             = count_r + 4'd1;
          end
        end
        MODE_DEQUEUE: begin
          if (count_r == '0) begin
            res_status = ST_EMPTY;
          end else begin
            res_slot = rd_addr;
          end
        end
        default: ;
      endcase

      if (do_unlink) begin
        // Bypass the slot from either side, then clear its own links.
        if (rd_addr == head_r) begin
          head_nxt = nx;
        end else begin
          next_nxt[pv] = nx;
        end
        if (rd_addr == tail_r) begin
          tail_nxt = pv;
        end else begin
          prev_nxt[nx] = pv;
        end
        queued_nxt[rd_addr] = 1'b0;
        next_nxt[rd_addr]   = '0;
        prev_nxt[rd_addr]   = '0;
        count_nxt           = count_r - 4'd1;
        // An emptied queue parks head and tail at zero.
        if (count_nxt == '0) begin
          head_nxt = '0;
          tail_nxt = '0;
        end
      end
    end
  end

  // --- registers ---------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      in_use_r    <= '0;
      queued_r    <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      in_use_r    <= in_use_nxt;
      queued_r    <= queued_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
    end
  end

  // Payload: request, result and links carry no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r <= mode_t'(in_tdata[1:0]);
      s1_slot_r <= in_tdata[4:2];
    end
    if (s1_fire) begin
      out_slot_r   <= res_slot;
      out_status_r <= res_status;
    end
    next_r <= next_nxt;
    prev_r <= prev_nxt;
  end

  // --- checks ------------------------------------------------------------
  `include "process_slot_pool_ready_queue_unit_assert.svh"

  `PSPQ_ASSERT(a_count_matches_queued, ($countones(queued_r) == int'(count_r)), "queue count disagrees with queued slots")
  `PSPQ_ASSERT_IMP(a_empty_parks_ends, (count_r == '0), ((head_r == '0) && (tail_r == '0)), "empty queue with nonzero head or tail")
  `PSPQ_ASSERT_IMP(a_single_entry_ends, (count_r == 4'd1), (head_r == tail_r), "single entry queue with head and tail apart")
  `PSPQ_ASSERT(a_queued_in_use, ((queued_r & ~in_use_low) == '0), "free slot found in the ready queue")
  `PSPQ_ASSERT(a_grant_onehot, $onehot0(grant), "allocation grants more than one slot")

endmodule

>>> verif/tb_process_slot_pool_ready_queue_unit.sv
`timescale 1ns / 1ps

module tb_process_slot_pool_ready_queue_unit;
  import pspq_pkg::*;

  localparam int RANDOM_ITEMS = 650;
  localparam int DRAIN_CYCLES = 8;   // settling margin after the last result
  localparam int PLAN_ROWS = 25;

  // One expected result: the slot handed back and the status code.
  typedef struct packed {
    slot_t   slot;
    status_t status;
  } pool_result_t;

  // One row of the directed plan. Rows marked fixed carry their answer;
  // the rest take it from the predictor.
  typedef struct packed {
    mode_t   mode;
    slot_t   slot;
    logic    fixed;
    slot_t   want_slot;
    status_t want_status;
  } plan_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;    // mode[1:0], slot[4:2], pad[7:5]
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;   // result_slot[2:0], status[4:3], pad[7:5]

  process_slot_pool_ready_queue_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Shadow copy of the pool and the ready queue, advanced once per accepted
  // request in the order the block takes them.
  logic       slot_busy   [LINK_DEPTH];
  logic       slot_linked [LINK_DEPTH];
  slot_t      link_next   [LINK_DEPTH];
  slot_t      link_prev   [LINK_DEPTH];
  slot_t      q_head;
  slot_t      q_tail;
  count_t     q_depth;

  pool_result_t pending_results [$];
  int           fail_count = 0;
  int           burst_left = 0;
  bit           steady = 1'b0;     // no sender gaps while set
  int unsigned  rx_cycle = 0;

  // Directed plan: empty-state answers, pool exhaustion, refusals, then
  // unlinking from the middle, the head, the tail and the last queued slot.
  plan_row_t plan [PLAN_ROWS] = '{
    '{MODE_DEQUEUE, 3'd0, 1'b1, 3'd0, ST_EMPTY},    // queue empty after reset
    '{MODE_RELEASE, 3'd0, 1'b1, 3'd0, ST_REFUSED},  // release of a free slot
    '{MODE_ENQUEUE, 3'd7, 1'b1, 3'd0, ST_REFUSED},  // enqueue of a free slot
    '{MODE_ALLOC,   3'd7, 1'b1, 3'd0, ST_OK},
    '{MODE_ALLOC,   3'd0, 1'b1, 3'd1, ST_OK},
    '{MODE_ALLOC,   3'd5, 1'b1, 3'd2, ST_OK},
    '{MODE_ALLOC,   3'd0, 1'b1, 3'd3, ST_OK},
    '{MODE_ALLOC,   3'd2, 1'b1, 3'd4, ST_OK},
    '{MODE_ALLOC,   3'd0, 1'b1, 3'd5, ST_OK},
    '{MODE_ALLOC,   3'd0, 1'b1, 3'd6, ST_OK},
    '{MODE_ALLOC,   3'd0, 1'b1, 3'd7, ST_OK},
    '{MODE_ALLOC,   3'd0, 1'b1, 3'd0, ST_EMPTY},    // pool exhausted
    '{MODE_ENQUEUE, 3'd3, 1'b0, 3'd0, ST_OK},
    '{MODE_ENQUEUE, 3'd5, 1'b0, 3'd0, ST_OK},
    '{MODE_ENQUEUE, 3'd7, 1'b0, 3'd0, ST_OK},
    '{MODE_ENQUEUE, 3'd0, 1'b0, 3'd0, ST_OK},
    '{MODE_ENQUEUE, 3'd5, 1'b1, 3'd0, ST_REFUSED},  // already queued
    '{MODE_RELEASE, 3'd5, 1'b0, 3'd0, ST_OK},       // unlink from the middle
    '{MODE_RELEASE, 3'd3, 1'b0, 3'd0, ST_OK},       // unlink the head
    '{MODE_RELEASE, 3'd0, 1'b0, 3'd0, ST_OK},       // unlink the tail
    '{MODE_RELEASE, 3'd7, 1'b0, 3'd0, ST_OK},       // last queued slot
    '{MODE_DEQUEUE, 3'd6, 1'b1, 3'd0, ST_EMPTY},    // queue emptied again
    '{MODE_ENQUEUE, 3'd6, 1'b0, 3'd0, ST_OK},
    '{MODE_DEQUEUE, 3'd0, 1'b0, 3'd0, ST_OK},
    '{MODE_RELEASE, 3'd6, 1'b0, 3'd0, ST_OK}
  };

  // Clock: 2 ns period.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Take a slot out of the ready queue wherever it sits; an emptied queue
  // parks head and tail at zero.
  function automatic void unlink_slot(input slot_t s);
    slot_t nx;
    slot_t pv;
    nx = link_next[s];
    pv = link_prev[s];
    if (s == q_head) q_head = nx;
    else link_next[pv] = nx;
    if (s == q_tail) q_tail = pv;
    else link_prev[nx] = pv;
    slot_linked[s] = 1'b0;
    link_next[s] = '0;
    link_prev[s] = '0;
    if (q_depth != '0) q_depth = q_depth - 4'd1;
    if (q_depth == '0) begin
      q_head = '0;
      q_tail = '0;
    end
  endfunction

  // Apply one request to the shadow state and return the answer it earns.
  function automatic pool_result_t predict_pool(input mode_t m, input slot_t s);
    pool_result_t r;
    r.slot = '0;
    r.status = ST_OK;
    case (m)
      MODE_ALLOC: begin
        r.status = ST_EMPTY;
        for (int i = 0; i < LINK_DEPTH; i++) begin
          if (!slot_busy[i] && r.status == ST_EMPTY) begin
            slot_busy[i] = 1'b1;
            r.slot = slot_t'(i);
            r.status = ST_OK;
          end
        end
      end
      MODE_RELEASE: begin
        if (!slot_busy[s]) begin
          r.status = ST_REFUSED;
        end else begin
          if (slot_linked[s]) unlink_slot(s);
          slot_busy[s] = 1'b0;
        end
      end
      MODE_ENQUEUE: begin
        if (!slot_busy[s] || slot_linked[s]) begin
          r.status = ST_REFUSED;
        end else begin
          if (q_depth == '0) begin
            q_head = s;
            link_prev[s] = '0;
          end else begin
            link_next[q_tail] = s;
            link_prev[s] = q_tail;
          end
          link_next[s] = '0;
          q_tail = s;
          slot_linked[s] = 1'b1;
          q_depth = q_depth + 4'd1;
        end
      end
      default: begin
        if (q_depth == '0) begin
          r.status = ST_EMPTY;
        end else begin
          r.slot = q_head;
          unlink_slot(q_head);
        end
      end
    endcase
    return r;
  endfunction

  // Present one request, hold it until the block takes it, then record what
  // it should answer. Fixed rows override the predicted answer, but the
  // predictor still advances so the shadow state stays in step.
  task automatic issue(input mode_t m, input slot_t s, input logic fixed,
                       input pool_result_t typed);
    pool_result_t predicted;
    int gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, s, m};
    do @(posedge clk); while (!in_tready);
    predicted = predict_pool(m, s);
    pending_results.push_back(fixed ? typed : predicted);
  endtask

  // Favor slots that make the request meaningful: busy slots for release,
  // busy and unqueued ones for enqueue. Now and then pick any slot.
  function automatic slot_t pick_slot(input bit for_enqueue);
    slot_t cands [$];
    for (int i = 0; i < LINK_DEPTH; i++)
      if (slot_busy[i] && !(for_enqueue && slot_linked[i])) cands.push_back(slot_t'(i));
    if (cands.size() == 0 || $urandom_range(0, 4) == 0) return slot_t'($urandom_range(0, 7));
    return cands[$urandom_range(0, cands.size() - 1)];
  endfunction

  // Receiver: check each result transfer against the oldest expectation, and
  // stall on a rotating pattern: always ready, random one-in-three stalls,
  // then a fixed stall whenever rx_cycle[2:0] is 5.
  always @(posedge clk) begin
    pool_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: result_slot %0d, status %0d",
               out_tdata[2:0], out_tdata[4:3]);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[2:0] !== want.slot) begin
          $error("result_slot: expected %0d, got %0d", want.slot, out_tdata[2:0]);
          fail_count++;
        end
        if (out_tdata[4:3] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tdata[4:3]);
          fail_count++;
        end
      end
    end
    rx_cycle++;
    case ((rx_cycle / 200) % 3)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 2) != 0);
      default: out_tready <= (rx_cycle[2:0] != 3'b101);
    endcase
  end

  // Main sequence: reset, directed plan, random traffic, drain.
  initial begin
    mode_t        m;
    slot_t        s;
    int           pick;
    int           alloc_weight;
    pool_result_t none;
    none = '{slot: '0, status: ST_OK};
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    for (int i = 0; i < LINK_DEPTH; i++) begin
      slot_busy[i]   = 1'b0;
      slot_linked[i] = 1'b0;
      link_next[i]   = '0;
      link_prev[i]   = '0;
    end
    q_head  = '0;
    q_tail  = '0;
    q_depth = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i])
      issue(plan[i].mode, plan[i].slot, plan[i].fixed,
            '{slot: plan[i].want_slot, status: plan[i].want_status});

    // Alternate allocate-heavy and release-heavy phases so the pool both
    // runs dry and drains; every third stretch runs without sender gaps.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = ((n / 100) % 3 == 2);
      alloc_weight = ((n / 80) % 2 == 0) ? 35 : 15;
      pick = $urandom_range(0, 99);
      if (pick < alloc_weight) begin
        m = MODE_ALLOC;
        s = slot_t'($urandom_range(0, 7));
      end else if (pick < alloc_weight + 20) begin
        m = MODE_RELEASE;
        s = pick_slot(1'b0);
      end else if (pick < alloc_weight + 50) begin
        m = MODE_ENQUEUE;
        s = pick_slot(1'b1);
      end else begin
        m = MODE_DEQUEUE;
        s = slot_t'($urandom_range(0, 7));
      end
      issue(m, s, 1'b0, none);
    end
    in_tvalid <= 1'b0;

    // Drain: wait for every expected result, then let the pipeline settle.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #200000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
